>>> rtl/strided_window_sum_scale_bias_unit_assert.svh
// Assertion macros for the strided window sum unit checker.
`ifndef STRIDED_WINDOW_SUM_SCALE_BIAS_UNIT_ASSERT_SVH
`define STRIDED_WINDOW_SUM_SCALE_BIAS_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define SWS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sws check failed");

// Next-cycle implication, off while reset is high.
`define SWS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sws check failed");

// Next-cycle implication, checked during reset too.
`define SWS_ASSERT_NEXT_ALL(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("sws check failed");

`endif

>>> rtl/sws_pkg.sv
// Shared types and constants for the strided window sum unit.
`default_nettype none

package sws_pkg;

   localparam int DEF_MAX_CHANNELS = 16;
   localparam int DEF_MAX_KERNEL   = 16;

   localparam int ACTION_W  = 2;
   localparam int CHAN_IN_W = 4;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 32;
   localparam int WEIGHT_W  = 16;
   localparam int RES_W     = 32;
   localparam int FRAME_W   = 16;
   localparam int FRAC_W    = 8;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SAMPLE      = 2'd0,
      ACT_LOAD_WEIGHT = 2'd1,
      ACT_LOAD_BIAS   = 2'd2,
      ACT_START       = 2'd3
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE          = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_IN_USE = 2'd2;

endpackage

`default_nettype wire

>>> rtl/strided_window_sum_scale_bias_unit.sv
// Top level: strided sum pooling over frames with per-channel weight and bias.
//
//  channel | handshake             | carries
//  --------+-----------------------+-----------------------------------------------
//  req     | req_valid / req_ready | action, channel, sample, coefficient
//  rsp     | rsp_valid / rsp_ready | result_value, result_channel, out_frame, done
//  csr     | csr_wr_en             | csr_index, csr_wdata (write only, no wait)
//
//  One item per cycle while rsp_ready keeps the pipe moving; a result passes from the
//  edge that takes its item through the history RAM read on that edge, then window
//  sum update, multiply and bias/saturate, each registered in turn.
//  Reset is synchronous and clears counters, window sums and coefficient tables;
//  the history RAM needs no clearing since entries are read only once written.
//  With rsp_ready low the result register holds and empty stages behind it
//  still fill, so req_ready drops only when every stage holds an item.
`default_nettype none

module strided_window_sum_scale_bias_unit #(
   parameter int MAX_CHANNELS = sws_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL   = sws_pkg::DEF_MAX_KERNEL
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_wr_en,
   input  logic [sws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sws_pkg::CSR_W-1:0]            csr_wdata,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sws_pkg::ACTION_W-1:0]         req_action,
   input  logic [sws_pkg::CHAN_IN_W-1:0]        req_channel,
   input  logic signed [sws_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic signed [sws_pkg::COEF_W-1:0]    req_coefficient,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sws_pkg::RES_W-1:0]     rsp_result_value,
   output logic [sws_pkg::CHAN_IN_W-1:0]        rsp_result_channel,
   output logic [sws_pkg::FRAME_W-1:0]          rsp_out_frame,
   output logic                                 rsp_frame_done
);

   import sws_pkg::*;

   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NC_W       = $clog2(MAX_CHANNELS + 1);
   localparam int KW_W       = $clog2(MAX_KERNEL + 1);
   localparam int SLOT_W     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int HIST_DEPTH = MAX_KERNEL * MAX_CHANNELS;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int SUM_W      = SAMPLE_W + $clog2(MAX_KERNEL);
   localparam int PROD_W     = SUM_W + WEIGHT_W;
   localparam int SHR_W      = PROD_W - FRAC_W;
   localparam int ACC_W      = ((SHR_W > RES_W) ? SHR_W : RES_W) + 1;

   function automatic logic [KW_W-1:0] clamp_kernel(input logic [CSR_W-1:0] v);
      logic [KW_W-1:0] r;
      if (v == '0) begin
         r = KW_W'(1);
      end else if (32'(v) > MAX_KERNEL) begin
         r = KW_W'(MAX_KERNEL);
      end else begin
         r = KW_W'(v);
      end
      return r;
   endfunction

   function automatic logic [NC_W-1:0] clamp_chan(input logic [CSR_W-1:0] v);
      logic [NC_W-1:0] r;
      if (v == '0) begin
         r = NC_W'(1);
      end else if (32'(v) > MAX_CHANNELS) begin
         r = NC_W'(MAX_CHANNELS);
      end else begin
         r = NC_W'(v);
      end
      return r;
   endfunction

   // fold the table channel into range: a small constant table
   function automatic logic [CH_W-1:0] chan_wrap(input logic [CHAN_IN_W-1:0] ch);
      logic [CH_W-1:0] r;
      r = '0;
      for (int i = 0; i < (1 << CHAN_IN_W); i++) begin
         if (ch == CHAN_IN_W'(i)) begin
            r = CH_W'(i % MAX_CHANNELS);
         end
      end
      return r;
   endfunction

   // settings and sequence counters
   logic [KW_W-1:0]    kw_ff, kw_in;
   logic [KW_W-1:0]    st_ff, st_in;
   logic [NC_W-1:0]    nc_ff, nc_in;
   logic [CH_W-1:0]    chan_ff, chan_in;
   logic [KW_W-1:0]    frames_ff, frames_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  phase_ff, phase_in;
   logic [FRAME_W-1:0] ofc_ff, ofc_in;

   // tables and running sums
   logic signed [WEIGHT_W-1:0] weight_ff [MAX_CHANNELS];
   logic signed [COEF_W-1:0]   bias_ff   [MAX_CHANNELS];
   logic signed [SUM_W-1:0]    sums_ff   [MAX_CHANNELS];

   // stage 1: history read returns
   logic                   v1_ff;
   action_type             s1_act_ff;
   logic [CH_W-1:0]        s1_ch_ff;
   logic [HIST_AW-1:0]     s1_addr_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic signed [COEF_W-1:0]   s1_coef_ff;
   logic                   s1_sub_ff;
   logic                   s1_emit_ff;
   logic                   s1_last_ff;
   logic [FRAME_W-1:0]     s1_frame_ff;
   logic                   byp_ff;
   logic [SAMPLE_W-1:0]    byp_data_ff;

   // stage 2: window sum ready for the multiply
   logic                   v2_ff;
   logic signed [SUM_W-1:0] s2_sum_ff;
   logic [CH_W-1:0]        s2_ch_ff;
   logic [FRAME_W-1:0]     s2_frame_ff;
   logic                   s2_last_ff;

   // stage 3: product and bias
   logic                   v3_ff;
   logic signed [PROD_W-1:0] s3_prod_ff;
   logic signed [COEF_W-1:0] s3_bias_ff;
   logic [CH_W-1:0]        s3_ch_ff;
   logic [FRAME_W-1:0]     s3_frame_ff;
   logic                   s3_last_ff;

   // result register
   logic                   rsp_valid_ff;
   logic signed [RES_W-1:0] rsp_value_ff;
   logic [CHAN_IN_W-1:0]   rsp_channel_ff;
   logic [FRAME_W-1:0]     rsp_frame_ff;
   logic                   rsp_done_ff;

   // flow control
   logic       rdy_out, rdy3, rdy2, rdy1;
   logic       accept, fire1;
   action_type req_act;

   // accept-stage decode
   logic [SLOT_W-1:0]  cur_slot;
   logic               cur_sub, cur_emit, cur_last, win_full;
   logic [HIST_AW-1:0] cur_addr;
   logic               seq_clear;
   logic               csr_start;

   // stage 1 datapath
   logic [SAMPLE_W-1:0]        hist_rd;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic signed [SUM_W-1:0]    sum_next;
   logic signed [WEIGHT_W-1:0] weight_sat;
   logic                       s1_is_sample;
   logic                       hist_we;

   // stage 3 datapath
   logic signed [SHR_W-1:0]  shr;
   logic signed [ACC_W-1:0]  acc;
   logic signed [RES_W-1:0]  res_sat;

   assign rdy_out   = !rsp_valid_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy_out;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign accept    = req_valid && rdy1;
   assign fire1     = v1_ff && rdy2;
   assign req_act   = action_type'(req_action);

   assign s1_is_sample = (s1_act_ff == ACT_SAMPLE);
   assign hist_we      = fire1 && s1_is_sample;

   // ---------------- accept stage: sequence counters ----------------
   always_comb begin
      cur_slot = (KW_W'(slot_ff) >= kw_ff) ? '0 : slot_ff;
      cur_sub  = (frames_ff >= kw_ff);
      win_full = ((KW_W+1)'(frames_ff) + (KW_W+1)'(1)) >= (KW_W+1)'(kw_ff);
      cur_emit = win_full && (phase_ff == '0);
      cur_last = (NC_W'(chan_ff) + NC_W'(1)) >= nc_ff;
      cur_addr = HIST_AW'(cur_slot) * HIST_AW'(MAX_CHANNELS) + HIST_AW'(chan_ff);
   end

   always_comb begin
      kw_in     = kw_ff;
      st_in     = st_ff;
      nc_in     = nc_ff;
      chan_in   = chan_ff;
      frames_in = frames_ff;
      slot_in   = slot_ff;
      phase_in  = phase_ff;
      ofc_in    = ofc_ff;
      csr_start = 1'b0;

      if (accept && (req_act == ACT_SAMPLE)) begin
         if (cur_last) begin
            chan_in = '0;
            if (win_full) begin
               phase_in = ((KW_W'(phase_ff) + KW_W'(1)) >= st_ff) ? '0
                          : phase_ff + SLOT_W'(1);
               if (cur_emit) begin
                  ofc_in = ofc_ff + FRAME_W'(1);
               end
            end
            if (frames_ff < kw_ff) begin
               frames_in = frames_ff + KW_W'(1);
            end
            slot_in = ((KW_W'(cur_slot) + KW_W'(1)) >= kw_ff) ? '0
                      : cur_slot + SLOT_W'(1);
         end else begin
            chan_in = chan_ff + CH_W'(1);
            slot_in = cur_slot;
         end
      end

      if (csr_wr_en) begin
         case (csr_index)
            CSR_KERNEL_WIDTH: begin
               kw_in     = clamp_kernel(csr_wdata);
               csr_start = 1'b1;
            end
            CSR_STRIDE: begin
               st_in     = clamp_kernel(csr_wdata);
               csr_start = 1'b1;
            end
            CSR_CHANNELS_IN_USE: begin
               nc_in     = clamp_chan(csr_wdata);
               csr_start = 1'b1;
            end
            default: ;
         endcase
      end

      seq_clear = csr_start || (accept && (req_act == ACT_START));
      if (seq_clear) begin
         chan_in   = '0;
         frames_in = '0;
         slot_in   = '0;
         phase_in  = '0;
         ofc_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff     <= KW_W'(1);
         st_ff     <= KW_W'(1);
         nc_ff     <= NC_W'(1);
         chan_ff   <= '0;
         frames_ff <= '0;
         slot_ff   <= '0;
         phase_ff  <= '0;
         ofc_ff    <= '0;
      end else begin
         kw_ff     <= kw_in;
         st_ff     <= st_in;
         nc_ff     <= nc_in;
         chan_ff   <= chan_in;
         frames_ff <= frames_in;
         slot_ff   <= slot_in;
         phase_ff  <= phase_in;
         ofc_ff    <= ofc_in;
      end
   end

   // ---------------- sample history ----------------
   sws_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (HIST_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (accept),
      .rd_addr (cur_addr),
      .rd_data (hist_rd)
   );

   // ---------------- stage 1 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff    <= req_act;
         s1_ch_ff     <= (req_act == ACT_SAMPLE) ? chan_ff : chan_wrap(req_channel);
         s1_addr_ff   <= cur_addr;
         s1_sample_ff <= req_sample;
         s1_coef_ff   <= req_coefficient;
         s1_sub_ff    <= cur_sub;
         s1_emit_ff   <= cur_emit;
         s1_last_ff   <= cur_last;
         s1_frame_ff  <= ofc_ff;
         // forward the sample being written this edge to a read of the same slot
         byp_ff       <= hist_we && (s1_addr_ff == cur_addr);
         byp_data_ff  <= s1_sample_ff;
      end
   end

   always_comb begin
      old_sample = byp_ff ? signed'(byp_data_ff) : signed'(hist_rd);
      sum_next   = sums_ff[s1_ch_ff] + SUM_W'(s1_sample_ff)
                   - (s1_sub_ff ? SUM_W'(old_sample) : {SUM_W{1'b0}});
      if (s1_coef_ff > 32'sd32767) begin
         weight_sat = 16'sh7FFF;
      end else if (s1_coef_ff < -32'sd32768) begin
         weight_sat = 16'sh8000;
      end else begin
         weight_sat = s1_coef_ff[WEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_start || (fire1 && (s1_act_ff == ACT_START))) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            sums_ff[i] <= '0;
         end
      end else if (hist_we) begin
         sums_ff[s1_ch_ff] <= sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            weight_ff[i] <= '0;
            bias_ff[i]   <= '0;
         end
      end else if (fire1) begin
         if (s1_act_ff == ACT_LOAD_WEIGHT) begin
            weight_ff[s1_ch_ff] <= weight_sat;
         end
         if (s1_act_ff == ACT_LOAD_BIAS) begin
            bias_ff[s1_ch_ff] <= s1_coef_ff;
         end
      end
   end

   // ---------------- stage 2 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff && s1_is_sample && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire1) begin
         s2_sum_ff   <= sum_next;
         s2_ch_ff    <= s1_ch_ff;
         s2_frame_ff <= s1_frame_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // ---------------- stage 3 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         s3_prod_ff  <= s2_sum_ff * weight_ff[s2_ch_ff];
         s3_bias_ff  <= bias_ff[s2_ch_ff];
         s3_ch_ff    <= s2_ch_ff;
         s3_frame_ff <= s2_frame_ff;
         s3_last_ff  <= s2_last_ff;
      end
   end

   // ---------------- result ----------------
   always_comb begin
      // dropping the fraction bits floors toward minus infinity
      shr = s3_prod_ff[PROD_W-1:FRAC_W];
      acc = ACC_W'(shr) + ACC_W'(s3_bias_ff);
      if ((acc[ACC_W-1:RES_W-1] == '0) || (acc[ACC_W-1:RES_W-1] == '1)) begin
         res_sat = acc[RES_W-1:0];
      end else if (acc[ACC_W-1]) begin
         res_sat = {1'b1, {(RES_W-1){1'b0}}};
      end else begin
         res_sat = {1'b0, {(RES_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy_out) begin
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff && rdy_out) begin
         rsp_value_ff   <= res_sat;
         rsp_channel_ff <= CHAN_IN_W'(s3_ch_ff);
         rsp_frame_ff   <= s3_frame_ff;
         rsp_done_ff    <= s3_last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_value_ff;
   assign rsp_result_channel = rsp_channel_ff;
   assign rsp_out_frame      = rsp_frame_ff;
   assign rsp_frame_done     = rsp_done_ff;

endmodule

`default_nettype wire

>>> rtl/sws_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/sws_checker.sv
// Port-level checker for the strided window sum unit, bound to the top level.
`default_nettype none

`include "strided_window_sum_scale_bias_unit_assert.svh"

module sws_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [sws_pkg::RES_W-1:0]    rsp_result_value,
   input logic [sws_pkg::CHAN_IN_W-1:0]       rsp_result_channel,
   input logic [sws_pkg::FRAME_W-1:0]         rsp_out_frame,
   input logic                                rsp_frame_done
);

   // after reset the pipe is empty: no result, input open
   `SWS_ASSERT_NEXT_ALL(a_reset_empty, reset, !rsp_valid && req_ready)

   // input stalls only when every stage is full, so the result must be blocked
   `SWS_ASSERT_NOW(a_stall_from_output, req_valid && !req_ready, rsp_valid && !rsp_ready)

   // hold a blocked result
   `SWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_result_channel) && $stable(rsp_out_frame) && $stable(rsp_frame_done))

endmodule

bind strided_window_sum_scale_bias_unit sws_checker u_sws_checker (.*);

`default_nettype wire

>>> test/strided_window_sum_scale_bias_unit_check.sv
// Checker for the strided window sum unit: tracks pooling state, predicts and compares results.
module strided_window_sum_scale_bias_unit_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [sws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sws_pkg::CSR_W-1:0]            csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [sws_pkg::ACTION_W-1:0]         req_action,
   input  logic [sws_pkg::CHAN_IN_W-1:0]        req_channel,
   input  logic signed [sws_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic signed [sws_pkg::COEF_W-1:0]    req_coefficient,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [sws_pkg::RES_W-1:0]     rsp_result_value,
   input  logic [sws_pkg::CHAN_IN_W-1:0]        rsp_result_channel,
   input  logic [sws_pkg::FRAME_W-1:0]          rsp_out_frame,
   input  logic                                 rsp_frame_done,
   output int                                   mismatches,
   output int                                   pending_results,
   output int                                   results_checked
);
   import sws_pkg::*;

   localparam int NCH  = DEF_MAX_CHANNELS;
   localparam int NKER = DEF_MAX_KERNEL;
   localparam longint RES_MAX = 64'sd2147483647;
   localparam longint RES_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [RES_W-1:0]     value;
      logic [CHAN_IN_W-1:0] chan;
      logic [FRAME_W-1:0]   frame;
      logic                 done;
   } pool_result_type;

   logic [CSR_W-1:0]           kernel_reg, stride_reg, chans_reg;
   logic signed [WEIGHT_W-1:0] weights [NCH];
   logic signed [COEF_W-1:0]   biases [NCH];
   logic signed [SAMPLE_W-1:0] history [NKER*NCH];
   int                         sums [NCH];
   int                         chan_pos, frames_filled, slot, stride_pos;
   logic [FRAME_W-1:0]         frame_num;
   pool_result_type            expected_pools [$];
   int                         fails, checks;

   function automatic int clamp_setting(logic [CSR_W-1:0] v, int hi);
      if (v == 0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   task automatic restart_sequence();
      for (int i = 0; i < NCH; i++) sums[i] = 0;
      chan_pos = 0;
      frames_filled = 0;
      slot = 0;
      stride_pos = 0;
      frame_num = '0;
   endtask

   task automatic advance_pooling(logic [ACTION_W-1:0] act, logic [CHAN_IN_W-1:0] tch,
                                  logic signed [SAMPLE_W-1:0] smp,
                                  logic signed [COEF_W-1:0] coef);
      int kw, st, nc, c, idx;
      longint prod, total;
      logic emit, last;
      pool_result_type res;
      kw = clamp_setting(kernel_reg, NKER);
      st = clamp_setting(stride_reg, NKER);
      nc = clamp_setting(chans_reg, NCH);
      case (action_type'(act))
         ACT_LOAD_WEIGHT: begin
            if (coef > 32767) weights[tch] = 16'sh7fff;
            else if (coef < -32768) weights[tch] = 16'sh8000;
            else weights[tch] = coef[WEIGHT_W-1:0];
         end
         ACT_LOAD_BIAS: biases[tch] = coef;
         ACT_START: restart_sequence();
         default: begin
            c = chan_pos % nc;
            if (slot >= kw) slot = 0;
            idx = slot * NCH + c;
            // once the window is full, drop the sample leaving it
            if (frames_filled >= kw) sums[c] = sums[c] + int'(smp) - int'(history[idx]);
            else sums[c] = sums[c] + int'(smp);
            history[idx] = smp;
            emit = (frames_filled + 1 >= kw) && (stride_pos == 0);
            last = (c + 1 >= nc);
            if (emit) begin
               // arithmetic shift floors toward minus infinity
               prod = longint'(sums[c]) * longint'(weights[c]);
               total = (prod >>> FRAC_W) + longint'(biases[c]);
               if (total > RES_MAX) total = RES_MAX;
               if (total < RES_MIN) total = RES_MIN;
               res.value = total[RES_W-1:0];
               res.chan  = c[CHAN_IN_W-1:0];
               res.frame = frame_num;
               res.done  = last;
               expected_pools.push_back(res);
            end
            if (last) begin
               chan_pos = 0;
               if (frames_filled + 1 >= kw) begin
                  stride_pos = (stride_pos + 1 >= st) ? 0 : stride_pos + 1;
                  if (emit) frame_num = frame_num + 1'b1;
               end
               if (frames_filled < kw) frames_filled++;
               slot = (slot + 1 >= kw) ? 0 : slot + 1;
            end else begin
               chan_pos = c + 1;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      pool_result_type want;
      if (reset) begin
         kernel_reg = CSR_W'(1);
         stride_reg = CSR_W'(1);
         chans_reg  = CSR_W'(1);
         for (int i = 0; i < NCH; i++) begin
            weights[i] = '0;
            biases[i]  = '0;
         end
         restart_sequence();
         expected_pools.delete();
         fails  = 0;
         checks = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pools.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected result: value %0d channel %0d frame %0d done %0b",
                           rsp_result_value, rsp_result_channel, rsp_out_frame,
                           rsp_frame_done);
            end else begin
               want = expected_pools.pop_front();
               checks++;
               if (rsp_result_value !== want.value || rsp_result_channel !== want.chan ||
                   rsp_out_frame !== want.frame || rsp_frame_done !== want.done) begin
                  fails++;
                  if (fails <= 10)
                     $display({"result mismatch: expected value %0d channel %0d frame %0d",
                               " done %0b, got value %0d channel %0d frame %0d done %0b"},
                              $signed(want.value), want.chan, want.frame, want.done,
                              rsp_result_value, rsp_result_channel, rsp_out_frame,
                              rsp_frame_done);
               end
            end
         end
         if (req_valid && req_ready)
            advance_pooling(req_action, req_channel, req_sample, req_coefficient);
         // any mapped register write also restarts the sequence
         if (csr_wr_en) begin
            case (csr_index)
               CSR_KERNEL_WIDTH: begin
                  kernel_reg = csr_wdata;
                  restart_sequence();
               end
               CSR_STRIDE: begin
                  stride_reg = csr_wdata;
                  restart_sequence();
               end
               CSR_CHANNELS_IN_USE: begin
                  chans_reg = csr_wdata;
                  restart_sequence();
               end
               default: ;
            endcase
         end
      end
      mismatches      <= fails;
      pending_results <= expected_pools.size();
      results_checked <= checks;
   end

endmodule

>>> test/strided_window_sum_scale_bias_unit_tb.sv
// Testbench top for the strided window sum unit: clock, reset, stimulus and verdict.
module strided_window_sum_scale_bias_unit_tb;
   import sws_pkg::*;

   localparam int ITEM_GOAL    = 1650;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_W-1:0]           csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [ACTION_W-1:0]        req_action = '0;
   logic [CHAN_IN_W-1:0]       req_channel = '0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic signed [COEF_W-1:0]   req_coefficient = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [RES_W-1:0]    rsp_result_value;
   logic [CHAN_IN_W-1:0]       rsp_result_channel;
   logic [FRAME_W-1:0]         rsp_out_frame;
   logic                       rsp_frame_done;

   int mismatches, pending_results, results_checked;
   int items_sent = 0;
   int settings_used = 0;
   int holds_done = 0;
   int next_hold_at = 300;
   bit quiet_sender = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   strided_window_sum_scale_bias_unit dut (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_action, .req_channel, .req_sample, .req_coefficient,
      .rsp_valid, .rsp_ready, .rsp_result_value, .rsp_result_channel, .rsp_out_frame,
      .rsp_frame_done
   );

   strided_window_sum_scale_bias_unit_check pool_check (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_action, .req_channel, .req_sample, .req_coefficient,
      .rsp_valid, .rsp_ready, .rsp_result_value, .rsp_result_channel, .rsp_out_frame,
      .rsp_frame_done, .mismatches, .pending_results, .results_checked
   );

   // mostly back to back, sometimes a few cycles, rarely a long gap
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [COEF_W-1:0] pick_coefficient();
      case ($urandom_range(0, 5))
         0: return COEF_W'($urandom);
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3: return COEF_W'($urandom_range(0, 65535)) - 32'sd32768;
         default: return COEF_W'($urandom_range(0, 1023)) - 32'sd512;
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] corner_setting(int k);
      case (k % 4)
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd16;
         default: return 5'd31;
      endcase
   endfunction

   function automatic int in_use(logic [CSR_W-1:0] v);
      if (v == 0) return 1;
      if (v > 16) return 16;
      return int'(v);
   endfunction

   task automatic offer_item(action_type act, logic [CHAN_IN_W-1:0] ch,
                             logic signed [SAMPLE_W-1:0] smp,
                             logic signed [COEF_W-1:0] coef);
      int gap;
      gap = quiet_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_channel     <= ch;
      req_sample      <= smp;
      req_coefficient <= coef;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // hold until every result is back and items with no result have left the pipe
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_window(logic [CSR_W-1:0] kw, logic [CSR_W-1:0] st,
                                 logic [CSR_W-1:0] nc);
      wait_until_drained();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_KERNEL_WIDTH;
      csr_wdata <= kw;
      @(posedge clock);
      csr_index <= CSR_STRIDE;
      csr_wdata <= st;
      @(posedge clock);
      csr_index <= CSR_CHANNELS_IN_USE;
      csr_wdata <= nc;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin : receiver
      int stall;
      bit steady;
      steady = 1'b0;
      forever begin
         // long hold-off so the pipe fills and the input stalls
         if (items_sent >= next_hold_at) begin
            next_hold_at = next_hold_at + 800;
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = steady ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) steady = !steady;
      end
   end

   initial begin : stimulus
      logic [CSR_W-1:0] kw, st, nc;
      int phase_items, frames, nc_eff, sample_style, r, waited;
      bit unmapped_done;
      logic signed [SAMPLE_W-1:0] smp;
      unmapped_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one channel, one-frame window, stride one: saturation and rounding edges
      offer_item(ACT_LOAD_WEIGHT, 4'd0, 16'sd0, 32'sh7fffffff);
      offer_item(ACT_LOAD_BIAS, 4'd0, 16'sd0, 32'sh7fffffff);
      offer_item(ACT_SAMPLE, 4'd9, 16'sh7fff, 32'sd0);
      offer_item(ACT_LOAD_WEIGHT, 4'd0, 16'sd0, 32'sh80000000);
      offer_item(ACT_LOAD_BIAS, 4'd0, 16'sd0, 32'sh80000000);
      offer_item(ACT_SAMPLE, 4'd0, 16'sh7fff, 32'sd0);
      offer_item(ACT_SAMPLE, 4'd0, 16'sh8000, 32'sd0);
      offer_item(ACT_LOAD_BIAS, 4'd0, 16'sd0, 32'sd0);
      offer_item(ACT_LOAD_WEIGHT, 4'd0, 16'sd0, 32'sd1);
      offer_item(ACT_SAMPLE, 4'd0, -16'sd1, 32'sd0);
      offer_item(ACT_SAMPLE, 4'd0, 16'sd255, 32'sd0);
      offer_item(ACT_LOAD_WEIGHT, 4'd15, 16'sd0, 32'sd32768);
      offer_item(ACT_LOAD_WEIGHT, 4'd15, 16'sd0, -32'sd32769);
      offer_item(ACT_LOAD_BIAS, 4'd15, 16'sd0, 32'sd12345);

      // window of three frames, stride two, two channels, then a restart mid-frame
      program_window(5'd3, 5'd2, 5'd2);
      offer_item(ACT_LOAD_WEIGHT, 4'd1, 16'sd0, 32'sd256);
      for (int i = 0; i < 6; i++)
         offer_item(ACT_SAMPLE, 4'd0, SAMPLE_W'(i * 1000 - 2000), 32'sd0);
      offer_item(ACT_SAMPLE, 4'd0, 16'sd7, 32'sd0);
      offer_item(ACT_START, 4'd0, 16'sd0, 32'sd0);
      offer_item(ACT_SAMPLE, 4'd0, -16'sd300, 32'sd0);

      // zero registers act as one
      program_window(5'd0, 5'd0, 5'd0);
      offer_item(ACT_SAMPLE, 4'd3, -16'sd512, 32'sd0);

      while (items_sent < ITEM_GOAL) begin
         case (settings_used % 4)
            0: begin
               kw = CSR_W'($urandom);
               st = CSR_W'($urandom);
               nc = CSR_W'($urandom);
            end
            1: begin
               kw = CSR_W'($urandom_range(1, 4));
               st = CSR_W'($urandom_range(1, 4));
               nc = CSR_W'($urandom_range(1, 4));
            end
            2: begin
               kw = corner_setting(settings_used / 4);
               st = corner_setting(settings_used / 4 + 1);
               nc = corner_setting(settings_used / 4 + 2);
            end
            default: begin
               kw = CSR_W'($urandom_range(1, 16));
               st = CSR_W'($urandom_range(1, 16));
               nc = CSR_W'($urandom_range(1, 16));
            end
         endcase
         program_window(kw, st, nc);
         nc_eff = in_use(nc);
         frames = in_use(kw) + $urandom_range(0, 2 * in_use(st) + 3);
         if (frames * nc_eff > 400) frames = 400 / nc_eff;
         phase_items = frames * nc_eff;
         sample_style = $urandom_range(0, 2);
         quiet_sender = ($urandom_range(0, 3) == 0);

         for (int ch = 0; ch < 16; ch++) begin
            if ($urandom_range(0, 2) == 0) begin
               offer_item(ACT_LOAD_WEIGHT, CHAN_IN_W'(ch), SAMPLE_W'($urandom),
                          pick_coefficient());
               offer_item(ACT_LOAD_BIAS, CHAN_IN_W'(ch), SAMPLE_W'($urandom),
                          pick_coefficient());
            end
         end

         for (int n = 0; n < phase_items && items_sent < ITEM_GOAL; n++) begin
            // an unmapped register write must leave the sequence running
            if (!unmapped_done && settings_used % 4 == 3 && n == phase_items / 2) begin
               wait_until_drained();
               csr_wr_en <= 1'b1;
               csr_index <= CSR_UNMAPPED;
               csr_wdata <= CSR_W'($urandom);
               @(posedge clock);
               csr_wr_en <= 1'b0;
               unmapped_done = 1'b1;
            end
            case (sample_style)
               0: smp = SAMPLE_W'($urandom);
               1: begin
                  case ($urandom_range(0, 3))
                     0: smp = 16'sh7fff;
                     1: smp = 16'sh8000;
                     2: smp = 16'sd0;
                     default: smp = -16'sd1;
                  endcase
               end
               default: smp = SAMPLE_W'($urandom_range(0, 200)) - 16'sd100;
            endcase
            r = $urandom_range(0, 199);
            if (r == 0)
               offer_item(ACT_START, CHAN_IN_W'($urandom), smp, COEF_W'($urandom));
            else if (r < 5)
               offer_item(r < 3 ? ACT_LOAD_WEIGHT : ACT_LOAD_BIAS, CHAN_IN_W'($urandom),
                          smp, pick_coefficient());
            else
               offer_item(ACT_SAMPLE, CHAN_IN_W'($urandom), smp, COEF_W'($urandom));
         end
      end

      req_valid <= 1'b0;
      quiet_sender = 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_results != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      $display("run covered %0d items over %0d register settings with %0d long output holds;",
               items_sent, settings_used, holds_done);
      $display("%0d results compared, %0d still outstanding", results_checked,
               pending_results);
      if (mismatches == 0 && pending_results == 0)
         $display("strided_window_sum_scale_bias_unit_tb OK");
      else
         $display("strided_window_sum_scale_bias_unit_tb NOT OK");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("strided_window_sum_scale_bias_unit_tb NOT OK");
      $finish;
   end

endmodule
